### rtl/asd_pkg.sv
// Package for the accelerometer step detector: word types, constants and tables.
// No dependencies; imported by every module of the block.
`default_nettype none
package asd_pkg;
	typedef struct packed {
		logic signed [7:0] axis_x;
		logic signed [7:0] axis_y;
		logic signed [7:0] axis_z;
		logic [1:0]        func;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         event_code;
		logic signed [15:0] filtered_energy;
	} out_word_t;

	typedef struct packed {
		logic [14:0] sleep_reset_count;
		logic [14:0] idle_sample_limit;
		logic [14:0] phase_time_limit;
		logic [11:0] rise_start_base;
		logic [11:0] rise_confirm_base;
		logic [11:0] fall_start_base;
		logic [11:0] fall_confirm_base;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic sq_en;
		logic [1:0] sq_sel;
		logic smooth;
		logic pred_a;
		logic pred_b;
		logic detect;
	} cmd_t;

	localparam logic [2:0] REG_SLEEP = 3'd0;
	localparam logic [2:0] REG_IDLE  = 3'd1;
	localparam logic [2:0] REG_PTIME = 3'd2;
	localparam logic [2:0] REG_RS    = 3'd3;
	localparam logic [2:0] REG_RC    = 3'd4;
	localparam logic [2:0] REG_FS    = 3'd5;
	localparam logic [2:0] REG_FC    = 3'd6;

	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_STEP  = 3'd1;
	localparam logic [2:0] EV_FIVE  = 3'd2;
	localparam logic [2:0] EV_SLEEP = 3'd3;
	localparam logic [2:0] EV_IDLE  = 3'd4;

	localparam logic [1:0] PH_RISE1 = 2'd0;
	localparam logic [1:0] PH_RISE2 = 2'd1;
	localparam logic [1:0] PH_FALL1 = 2'd2;
	localparam logic [1:0] PH_FALL2 = 2'd3;

	localparam logic [1:0] FN_STEP    = 2'd0;
	localparam logic [1:0] FN_CONFIRM = 2'd1;
	localparam logic [1:0] FN_CLEAR   = 2'd2;

	function automatic logic [8:0] gain_q8(input logic [1:0] g);
		case (g)
			2'd0: gain_q8 = 9'd205;
			2'd1: gain_q8 = 9'd192;
			2'd2: gain_q8 = 9'd179;
			default: gain_q8 = 9'd154;
		endcase
	endfunction

	function automatic logic [7:0] off_a(input logic [2:0] b);
		case (b)
			3'd1: off_a = 8'h18;
			3'd2: off_a = 8'h38;
			3'd3: off_a = 8'h68;
			3'd4: off_a = 8'hA0;
			default: off_a = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] off_b(input logic [2:0] b);
		case (b)
			3'd1: off_b = 8'h18;
			3'd2: off_b = 8'h28;
			3'd3: off_b = 8'h60;
			3'd4: off_b = 8'h90;
			default: off_b = 8'h00;
		endcase
	endfunction

	function automatic logic signed [4:0] dev_low(input logic [4:0] i);
		case (i)
			5'd6, 5'd7, 5'd8, 5'd9: dev_low = -5'sd1;
			5'd10, 5'd11: dev_low = -5'sd2;
			5'd12, 5'd13, 5'd14: dev_low = -5'sd3;
			5'd15, 5'd16, 5'd17, 5'd18: dev_low = -5'sd4;
			5'd19: dev_low = -5'sd5;
			5'd20: dev_low = -5'sd6;
			5'd21: dev_low = -5'sd7;
			5'd22: dev_low = -5'sd8;
			5'd23: dev_low = -5'sd9;
			5'd24: dev_low = -5'sd10;
			default: dev_low = 5'sd0;
		endcase
	endfunction

	function automatic logic signed [4:0] dev_high(input logic [4:0] i);
		case (i)
			5'd6, 5'd7, 5'd22: dev_high = 5'sd2;
			5'd8, 5'd20, 5'd21: dev_high = 5'sd3;
			5'd9, 5'd10, 5'd11, 5'd12, 5'd19: dev_high = 5'sd4;
			5'd13, 5'd15, 5'd16, 5'd17, 5'd18: dev_high = 5'sd5;
			5'd14: dev_high = 5'sd6;
			5'd23: dev_high = 5'sd1;
			default: dev_high = 5'sd0;
		endcase
	endfunction

	function automatic logic [1:0] gain_for(input logic [7:0] iv);
		if (iv <= 8'd8) gain_for = 2'd3;
		else if (iv <= 8'd10) gain_for = 2'd2;
		else if (iv <= 8'd12) gain_for = 2'd1;
		else gain_for = 2'd0;
	endfunction

	function automatic logic [2:0] band_for(input logic [7:0] iv);
		if (iv >= 8'd15) band_for = 3'd0;
		else if (iv >= 8'd12) band_for = 3'd1;
		else if (iv >= 8'd10) band_for = 3'd2;
		else if (iv >= 8'd8) band_for = 3'd3;
		else band_for = 3'd4;
	endfunction
endpackage
`default_nettype wire

### rtl/accel_step_detector.sv
// Top level of the accelerometer step detector: ports, configuration registers, output slot.
// Depends on asd_pkg, asd_ctrl and asd_dp.
`default_nettype none
// A word is accepted only while idle, and the next only after the detector update of the last.
// Each word passes in order through the squares of x, y, z (x in the accepting cycle) in the one
// shared 8x8 squarer, then smoothing, the gain multiply of the extrapolation and detector update.
// The result waits in the output register while the next word is accepted; the detector update
// waits only if that register is still full and not being taken.
module accel_step_detector (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  asd_pkg::in_word_t         in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output asd_pkg::out_word_t        out_data,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [14:0]          cfg_data
);
	import asd_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	logic out_load, in_fire;

	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sleep_reset_count <= 15'd50;
			cfg_q.idle_sample_limit <= 15'd250;
			cfg_q.phase_time_limit <= 15'd300;
			cfg_q.rise_start_base <= 12'd112;
			cfg_q.rise_confirm_base <= 12'd48;
			cfg_q.fall_start_base <= 12'd112;
			cfg_q.fall_confirm_base <= 12'd48;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLEEP: cfg_q.sleep_reset_count <= cfg_data;
				REG_IDLE:  cfg_q.idle_sample_limit <= cfg_data;
				REG_PTIME: cfg_q.phase_time_limit <= cfg_data;
				REG_RS:    cfg_q.rise_start_base <= cfg_data[11:0];
				REG_RC:    cfg_q.rise_confirm_base <= cfg_data[11:0];
				REG_FS:    cfg_q.fall_start_base <= cfg_data[11:0];
				REG_FC:    cfg_q.fall_confirm_base <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	asd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(out_valid && !out_ready), .in_ready(in_ready),
		.out_load(out_load), .cmd(cmd)
	);

	asd_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_word(in_data),
		.cfg(cfg_q), .res(out_data)
	);
endmodule
`default_nettype wire

### rtl/asd_ctrl.sv
// Sequencer of the step detector: steps each word through squares, filter and detector.
// Depends on asd_pkg.
`default_nettype none
module asd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_fire,
	input  wire logic          out_busy,
	output logic               in_ready,
	output logic               out_load,
	output asd_pkg::cmd_t      cmd
);
	import asd_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQY  = 3'd1;
	localparam logic [2:0] S_SQZ  = 3'd2;
	localparam logic [2:0] S_PA   = 3'd3;
	localparam logic [2:0] S_PB   = 3'd4;
	localparam logic [2:0] S_DET  = 3'd5;
	localparam logic [2:0] S_WAIT = 3'd6;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		out_load = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					cmd.sq_en = 1'b1;
					cmd.sq_sel = 2'd0;
					state_d = S_SQY;
				end
			end
			S_SQY: begin
				cmd.sq_en = 1'b1;
				cmd.sq_sel = 2'd1;
				state_d = S_SQZ;
			end
			S_SQZ: begin
				cmd.sq_en = 1'b1;
				cmd.sq_sel = 2'd2;
				state_d = S_PA;
			end
			S_PA: begin
				cmd.smooth = 1'b1;
				state_d = S_PB;
			end
			S_PB: begin
				cmd.pred_a = 1'b1;
				state_d = S_DET;
			end
			S_DET: begin
				cmd.pred_b = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (!out_busy) begin
					cmd.detect = 1'b1;
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_fire_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_SQY) else $error("sequence not started");
	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> !out_load) else $error("double result load");
`endif
endmodule
`default_nettype wire

### rtl/asd_dp.sv
// Datapath of the step detector: energy, smoothing, extrapolation ring and detector state.
// Depends on asd_pkg; driven by asd_ctrl commands.
`default_nettype none
module asd_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  asd_pkg::cmd_t           cmd,
	input  asd_pkg::in_word_t       in_word,
	input  asd_pkg::cfg_t           cfg,
	output asd_pkg::out_word_t      res
);
	import asd_pkg::*;

	in_word_t in_q;
	logic [16:0] acc_q;
	logic [15:0] sm_q;
	logic signed [15:0] hist_q [4];
	logic [1:0]  hidx_q, gsel_q, phase_q;
	logic signed [16:0] rmin_q, rmax_q, ref_q;
	logic [15:0] ptime_q, since_q;
	logic [7:0]  reg_q, civ_q, piv_q;
	logic [2:0]  band_q;
	logic signed [26:0] pa_q;

	logic signed [7:0] sq_in;
	logic [14:0] sq_prod;
	always_comb begin
		case (cmd.sq_sel)
			2'd0: sq_in = in_word.axis_x;
			2'd1: sq_in = in_q.axis_y;
			default: sq_in = in_q.axis_z;
		endcase
		sq_prod = 15'(unsigned'(32'(sq_in * sq_in)));
	end

	logic [14:0] energy;
	logic [17:0] sm_sum;
	assign energy = (acc_q > 17'd32767) ? 15'd32767 : acc_q[14:0];
	assign sm_sum = 18'(sm_q) * 18'd3 + 18'(energy);

	logic [8:0] k;
	logic signed [17:0] lin;
	logic signed [26:0] pa_d;
	logic signed [26:0] pb_full;
	logic signed [26:0] pred_t;
	logic signed [15:0] pred_sat;
	assign k = gain_q8(gsel_q);
	assign lin = 18'(hist_q[hidx_q + 2'd3]) * 18'sd2 - 18'(hist_q[hidx_q + 2'd2]);
	assign pa_d = 27'(lin * $signed({1'b0, k}));
	assign pb_full = pa_q + 27'($signed({1'b0, 9'd256 - k}) * $signed({1'b0, sm_q}));
	always_comb begin
		pred_t = (pb_full < 0) ? -((-pb_full) >>> 8) : (pb_full >>> 8);
		if (pred_t > 27'sd32767) pred_sat = 16'sh7fff;
		else if (pred_t < -27'sd32768) pred_sat = 16'sh8000;
		else pred_sat = pred_t[15:0];
	end

	function automatic logic signed [16:0] q4(input logic signed [15:0] v);
		logic signed [16:0] e;
		e = 17'(v);
		q4 = (e < 0) ? -((-e) >>> 2) : (e >>> 2);
	endfunction
	logic signed [16:0] s;
	assign s = q4(hist_q[0]) + q4(hist_q[1]) + q4(hist_q[2]) + q4(hist_q[3]);

	logic signed [16:0] th1, th2, th3, th4;
	assign th1 = 17'(cfg.rise_start_base) + 17'(off_a(band_q));
	assign th2 = 17'(cfg.rise_confirm_base) + 17'(off_b(band_q));
	assign th3 = 17'(cfg.fall_start_base) + 17'(off_a(band_q));
	assign th4 = 17'(cfg.fall_confirm_base) + 17'(off_b(band_q));

	logic [1:0]  ph_n, gs_n, fn;
	logic signed [16:0] mn_n, mx_n, rf_n;
	logic [15:0] pt_n, ss_n;
	logic [7:0]  rc_n, ci_n, pi_n, iv;
	logic [2:0]  bd_n, ev;
	logic signed [8:0] dev;
	always_comb begin
		fn = in_q.func;
		ph_n = phase_q; gs_n = gsel_q; mn_n = rmin_q; mx_n = rmax_q; rf_n = ref_q;
		pt_n = ptime_q; ss_n = since_q; rc_n = reg_q; ci_n = civ_q; pi_n = piv_q;
		bd_n = band_q; ev = EV_NONE; iv = 8'd0; dev = '0;
		if (fn == FN_CLEAR) begin
			ss_n = '0; pt_n = '0; ph_n = PH_RISE1;
		end
		if (ci_n < 8'd127) ci_n = ci_n + 8'd1;
		case (ph_n)
			PH_RISE1: begin
				if (mn_n > s) mn_n = s;
				else begin
					pt_n = pt_n + 16'd1;
					if (s - mn_n > th1) begin
						rf_n = s; ph_n = PH_RISE2;
					end
				end
			end
			PH_RISE2: begin
				if (s - rf_n > th2) begin
					ph_n = PH_FALL1; mx_n = -17'sd32767; pt_n = '0;
				end else begin
					if (pt_n > 16'd8) begin
						ph_n = PH_RISE1; mn_n = 17'sd32767;
					end
					pt_n = pt_n + 16'd1;
				end
			end
			PH_FALL1: begin
				if (s > mx_n) mx_n = s;
				else if (s < mx_n - th3) begin
					rf_n = s; ph_n = PH_FALL2; pt_n = '0;
				end else begin
					if (pt_n > 16'd8) begin
						ph_n = PH_RISE1; mn_n = 17'sd32767;
					end
					pt_n = pt_n + 16'd1;
				end
			end
			default: begin
				if (s < rf_n - th4) begin
					iv = ci_n;
					ph_n = PH_RISE1; mn_n = 17'sd32767; pt_n = '0; ss_n = '0;
					if (fn == FN_CONFIRM) begin
						rc_n = rc_n + 8'd1;
						if (rc_n == 8'd3) pi_n = iv;
						else if (rc_n > 8'd3) begin
							dev = 9'(iv) - 9'(pi_n);
							if (pi_n < 8'd6 || pi_n > 8'd24) rc_n = rc_n - 8'd1;
							else if (dev < 9'(dev_low(pi_n[4:0]))
								|| dev > 9'(dev_high(pi_n[4:0]))) rc_n = '0;
							if (iv < 8'd6 || iv > 8'd24) rc_n = '0;
						end
						if (rc_n > 8'd0) gs_n = gain_for(iv);
						if (rc_n >= 8'd5) begin
							rc_n = '0; ev = EV_FIVE;
						end
					end else if (fn == FN_STEP) begin
						if (iv >= 8'd6) begin
							ev = EV_STEP; gs_n = gain_for(iv);
						end
					end
					pi_n = iv; bd_n = band_for(iv); ci_n = '0;
				end else begin
					if (pt_n > 16'd6) begin
						ph_n = PH_RISE1; mn_n = 17'sd32767;
					end
					pt_n = pt_n + 16'd1;
				end
			end
		endcase
		ss_n = ss_n + 16'd1;
		if (ss_n == 16'(cfg.sleep_reset_count)) begin
			bd_n = 3'd0; ph_n = PH_RISE1; mn_n = 17'sd255; rc_n = '0; ev = EV_SLEEP;
			gs_n = 2'd0;
		end
		if (pt_n > 16'(cfg.phase_time_limit) || ss_n > 16'(cfg.idle_sample_limit)) begin
			ev = EV_IDLE; gs_n = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_word;
		if (cmd.pred_a) pa_q <= pa_d;
		if (cmd.detect) begin
			res.event_code <= ev;
			res.filtered_energy <= s[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; sm_q <= '0; hidx_q <= '0; gsel_q <= '0; phase_q <= PH_RISE1;
			hist_q[0] <= '0; hist_q[1] <= '0; hist_q[2] <= '0; hist_q[3] <= '0;
			rmin_q <= 17'sd32767; rmax_q <= -17'sd32767; ref_q <= '0;
			ptime_q <= '0; since_q <= '0; reg_q <= '0; civ_q <= '0; piv_q <= '0;
			band_q <= '0;
		end else begin
			if (cmd.sq_en) acc_q <= (cmd.load ? 17'd0 : acc_q) + 17'(sq_prod);
			if (cmd.smooth) sm_q <= sm_sum[17:2];
			if (cmd.pred_b) begin
				hist_q[hidx_q] <= pred_sat;
				hidx_q <= hidx_q + 2'd1;
			end
			if (cmd.detect) begin
				phase_q <= ph_n; gsel_q <= gs_n; rmin_q <= mn_n; rmax_q <= mx_n;
				ref_q <= rf_n; ptime_q <= pt_n; since_q <= ss_n; reg_q <= rc_n;
				civ_q <= ci_n; piv_q <= pi_n; band_q <= bd_n;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_civ_sat: assert property (@(posedge clk) disable iff (!arst_n)
		civ_q <= 8'd127) else $error("interval past saturation");
	a_band: assert property (@(posedge clk) disable iff (!arst_n)
		band_q <= 3'd4) else $error("cadence band out of range");
	a_hidx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pred_b |=> hidx_q == $past(hidx_q) + 2'd1) else $error("ring index slip");
`endif
endmodule
`default_nettype wire
